// File: sv/bb3_pkg.sv
// shared types and constants of the 3x3 box blur
`default_nettype none

package bb3_pkg;

    // line store depth, the widest frame that the block takes
    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);

    localparam int WIDTH_W  = 11;
    localparam int HEIGHT_W = 16;
    // input row runs up to height + 1 while draining
    localparam int ROW_W    = HEIGHT_W + 1;
    localparam int CFG_W    = 16;
    localparam int SUM_W    = 12;
    localparam int CNT_W    = 4;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd480;

    typedef enum logic {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_index;

    // channel 2 red, 1 green, 0 blue
    typedef logic [2:0][7:0] t_pixel;

    typedef struct packed {
        logic       mode;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_in_item;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       frame_end;
    } t_out_item;

    // neighbourhood flags of the output pixel an item produces
    typedef struct packed {
        logic emit;
        logic last;
        logic top_ok;
        logic bot_ok;
        logic left_ok;
        logic right_ok;
    } t_edge_mask;

    typedef struct packed {
        logic [2:0][SUM_W-1:0] sum;
        logic [CNT_W-1:0]      count;
        logic                  last;
    } t_sums;

endpackage

`default_nettype wire

// File: sv/bb3_line_store.sv
// two row stores with registered read and write-to-read bypass
`default_nettype none

module bb3_line_store
    import bb3_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_rd_en,
    input  wire logic [COL_W-1:0] i_rd_addr,
    input  wire logic             i_wr_en,
    input  wire logic [COL_W-1:0] i_wr_addr,
    input  wire t_pixel           i_wr_pix,
    output t_pixel                o_top,
    output t_pixel                o_mid
);

    t_pixel r_older [MAX_WIDTH];
    t_pixel r_newer [MAX_WIDTH];
    t_pixel r_rd_top;
    t_pixel r_rd_mid;
    t_pixel r_byp_top;
    t_pixel r_byp_mid;
    logic   r_byp;

    // newer row moves down into older row, new pixel into newer row
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_older[i_wr_addr] <= o_mid;
            r_newer[i_wr_addr] <= i_wr_pix;
        end
        if (i_rd_en) begin
            r_rd_top  <= r_older[i_rd_addr];
            r_rd_mid  <= r_newer[i_rd_addr];
            r_byp_top <= o_mid;
            r_byp_mid <= i_wr_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp <= 1'b0;
        end else if (i_rd_en) begin
            r_byp <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    assign o_top = r_byp ? r_byp_top : r_rd_top;
    assign o_mid = r_byp ? r_byp_mid : r_rd_mid;

endmodule

`default_nettype wire

// File: sv/bb3_window.sv
// window columns and masked neighbourhood sums
`default_nettype none

module bb3_window
    import bb3_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_shift,
    input  wire t_pixel     i_top,
    input  wire t_pixel     i_mid,
    input  wire t_pixel     i_bot,
    input  wire t_edge_mask i_mask,
    output t_sums           o_sums
);

    // [row][col], row 0 top, col 0 left, col 1 centre; right column is the new one
    t_pixel r_win [3][2];
    t_pixel new_col [3];
    t_sums  r_sums;
    t_sums  n_sums;
    logic [2:0] row_en;
    logic [2:0] col_en;
    t_pixel     tap;

    assign new_col[0] = i_top;
    assign new_col[1] = i_mid;
    assign new_col[2] = i_bot;

    always_comb begin
        row_en = {i_mask.bot_ok, 1'b1, i_mask.top_ok};
        col_en = {i_mask.right_ok, 1'b1, i_mask.left_ok};
        n_sums = '0;
        tap    = '0;
        n_sums.last = i_mask.last;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                tap = (c == 2) ? new_col[r] : r_win[r][c];
                if (row_en[r] && col_en[c]) begin
                    for (int ch = 0; ch < 3; ch++) begin
                        n_sums.sum[ch] = n_sums.sum[ch] + SUM_W'(tap[ch]);
                    end
                    n_sums.count = n_sums.count + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= new_col[r];
            end
            if (i_mask.emit) begin
                r_sums <= n_sums;
            end
        end
    end

    assign o_sums = r_sums;

endmodule

`default_nettype wire

// File: sv/bb3_divide.sv
// rounded mean by reciprocal multiply, result register
`default_nettype none

module bb3_divide
    import bb3_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_load,
    input  wire t_sums i_sums,
    output t_out_item  o_item
);

    localparam int RCP_W = 17;
    localparam int RCP_SH = 16;
    localparam logic [RCP_W-1:0] RCP_1 = 17'd65536;
    localparam logic [RCP_W-1:0] RCP_3 = 17'd21846;
    localparam logic [RCP_W-1:0] RCP_9 = 17'd7282;

    t_out_item        r_item;
    logic [1:0]       shift;
    logic [RCP_W-1:0] rcp;
    logic [2:0][7:0]  quot;
    logic [SUM_W:0]   num;
    logic [SUM_W-1:0] part;
    logic [SUM_W+RCP_W-1:0] prod;

    // (2*sum + n) / (2*n): 2n = 2^shift * {1,3,9}
    always_comb begin
        case (i_sums.count)
            4'd2:    begin shift = 2'd2; rcp = RCP_1; end
            4'd3:    begin shift = 2'd1; rcp = RCP_3; end
            4'd4:    begin shift = 2'd3; rcp = RCP_1; end
            4'd6:    begin shift = 2'd2; rcp = RCP_3; end
            4'd9:    begin shift = 2'd1; rcp = RCP_9; end
            default: begin shift = 2'd1; rcp = RCP_1; end
        endcase
        num  = '0;
        part = '0;
        prod = '0;
        quot = '0;
        for (int ch = 0; ch < 3; ch++) begin
            num  = {i_sums.sum[ch], 1'b0} + (SUM_W+1)'(i_sums.count);
            part = SUM_W'(num >> shift);
            prod = (SUM_W+RCP_W)'(part) * (SUM_W+RCP_W)'(rcp);
            quot[ch] = prod[RCP_SH+7:RCP_SH];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item.red_out   <= quot[2];
            r_item.green_out <= quot[1];
            r_item.blue_out  <= quot[0];
            r_item.frame_end <= i_sums.last;
        end
    end

    assign o_item = r_item;

endmodule

`default_nettype wire

// File: sv/box_blur_3x3_edge_normalized_top.sv
// top level of the streaming 3x3 box blur with edge-normalized mean
//
//   port group     direction  handshake                 payload
//   input items    in         i_in_valid / o_in_stall   i_in_item  (t_in_item)
//   result items   out        o_out_valid / i_out_stall o_out_item (t_out_item)
//   configuration  in         i_cfg_we                  i_cfg_index, i_cfg_data
//
// one item per clock sustained while i_out_stall stays low; a result shows on o_out_valid
// once the item that causes it has passed the input register, sum register and
// result register, trailing the pixel stream by one row plus one pixel
// row stores are two-port memories with registered read, no clearing pass
// after reset: their stale entries only ever land on masked neighbours
// i_out_stall backs up through the result, sum and input registers to o_in_stall
// synchronous active-low reset clears counters and valid bits, sets geometry to 640x480
`default_nettype none

module box_blur_3x3_edge_normalized_top
    import bb3_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire t_in_item         i_in_item,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output t_out_item             o_out_item,
    input  wire logic             i_cfg_we,
    input  wire t_cfg_index       i_cfg_index,
    input  wire logic [CFG_W-1:0] i_cfg_data
);

    // frame geometry, already clamped to the legal range
    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;
    logic [WIDTH_W-1:0]  n_width;
    logic [HEIGHT_W-1:0] n_height;

    // input position counters
    logic [COL_W-1:0] r_ic;
    logic [ROW_W-1:0] r_ir;
    logic [COL_W-1:0] n_ic;
    logic [ROW_W-1:0] n_ir;

    // input register stage
    logic             r_s1_valid;
    t_pixel           r_s1_pix;
    logic [COL_W-1:0] r_s1_addr;
    t_edge_mask       r_s1_mask;

    logic r_s2_valid;
    logic r_out_valid;

    logic s1_adv;
    logic s2_adv;
    logic s2_free;
    logic accept;
    logic take;

    // per-item decode from the counters
    logic             draining;
    logic             act;
    logic             emit_prev_row;
    logic             emit_this_row;
    logic [ROW_W-1:0] orow;
    logic [COL_W-1:0] ocol;
    t_edge_mask       mask;
    t_pixel           pix;
    logic [WIDTH_W-1:0] ic_inc;
    logic [WIDTH_W-1:0] width_m1;

    logic [WIDTH_W-1:0] cfg_w;

    t_pixel store_top;
    t_pixel store_mid;
    t_sums  sums;

    // pipeline flow
    assign s2_adv     = r_s2_valid && (!r_out_valid || !i_out_stall);
    assign s2_free    = !r_s2_valid || s2_adv;
    assign s1_adv     = r_s1_valid && (!r_s1_mask.emit || s2_free);
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign accept     = i_in_valid && !o_in_stall;
    // drain ticks before the frame's last pixel and pixels while draining do nothing
    assign take       = accept && act;

    always_comb begin
        draining = r_ir >= ROW_W'(r_height);
        act      = i_in_item.mode ? draining : !draining;

        // start of a row finishes the last pixel of the row two above
        emit_prev_row = (r_ic == '0) && (r_ir >= ROW_W'(2));
        emit_this_row = (r_ic != '0) && (r_ir != '0);

        width_m1 = r_width - WIDTH_W'(1);
        orow = emit_prev_row ? (r_ir - ROW_W'(2)) : (r_ir - ROW_W'(1));
        ocol = emit_prev_row ? width_m1[COL_W-1:0] : (r_ic - COL_W'(1));

        mask.emit     = emit_prev_row || emit_this_row;
        mask.top_ok   = orow != '0;
        mask.bot_ok   = (orow + ROW_W'(1)) < ROW_W'(r_height);
        mask.left_ok  = ocol != '0;
        mask.right_ok = (WIDTH_W'(ocol) + WIDTH_W'(1)) < r_width;
        mask.last     = mask.emit && !mask.bot_ok && !mask.right_ok;

        pix = i_in_item.mode ? '0
                             : {i_in_item.red_in, i_in_item.green_in, i_in_item.blue_in};
        ic_inc = WIDTH_W'(r_ic) + WIDTH_W'(1);
    end

    // configuration clamp: width 0 counts as 1, above the store depth as the depth; height 0 as 1
    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        cfg_w    = i_cfg_data[WIDTH_W-1:0];
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH: begin
                    if (cfg_w == '0) begin
                        n_width = WIDTH_W'(1);
                    end else if (cfg_w > WIDTH_W'(MAX_WIDTH)) begin
                        n_width = WIDTH_W'(MAX_WIDTH);
                    end else begin
                        n_width = cfg_w;
                    end
                end
                CFG_FRAME_HEIGHT: begin
                    n_height = (i_cfg_data == '0) ? HEIGHT_W'(1) : i_cfg_data;
                end
                default: begin
                    n_width  = r_width;
                    n_height = r_height;
                end
            endcase
        end
    end

    // counters: a register write or the frame's last result restarts the frame
    always_comb begin
        n_ic = r_ic;
        n_ir = r_ir;
        if (i_cfg_we) begin
            n_ic = '0;
            n_ir = '0;
        end else if (take) begin
            if (mask.last) begin
                n_ic = '0;
                n_ir = '0;
            end else if (ic_inc >= r_width) begin
                n_ic = '0;
                n_ir = r_ir + ROW_W'(1);
            end else begin
                n_ic = ic_inc[COL_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= WIDTH_RESET;
            r_height    <= HEIGHT_RESET;
            r_ic        <= '0;
            r_ir        <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_width  <= n_width;
            r_height <= n_height;
            r_ic     <= n_ic;
            r_ir     <= n_ir;

            if (take) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_adv && r_s1_mask.emit) begin
                r_s2_valid <= 1'b1;
            end else if (s2_adv) begin
                r_s2_valid <= 1'b0;
            end

            if (s2_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_s1_pix  <= pix;
            r_s1_addr <= r_ic;
            r_s1_mask <= mask;
        end
    end

    bb3_line_store u_line_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (take),
        .i_rd_addr (r_ic),
        .i_wr_en   (s1_adv),
        .i_wr_addr (r_s1_addr),
        .i_wr_pix  (r_s1_pix),
        .o_top     (store_top),
        .o_mid     (store_mid)
    );

    bb3_window u_window (
        .i_clk   (i_clk),
        .i_shift (s1_adv),
        .i_top   (store_top),
        .i_mid   (store_mid),
        .i_bot   (r_s1_pix),
        .i_mask  (r_s1_mask),
        .o_sums  (sums)
    );

    bb3_divide u_divide (
        .i_clk  (i_clk),
        .i_load (s2_adv),
        .i_sums (sums),
        .o_item (o_out_item)
    );

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// File: sim/tb_box_blur_3x3_edge_normalized_top.sv
// self-checking testbench for the streaming 3x3 box blur with edge-normalized mean

module tb_box_blur_3x3_edge_normalized_top;
    import bb3_pkg::*;

    // item modes
    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_DRAIN = 1'b1;

    localparam int ITEM_GOAL     = 2000;
    // leave some margin before a register write
    localparam int SETTLE_CYCLES = 8;
    // long receiver hold-off that backs the pipeline up into the input
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 1_500_000;

    typedef enum logic {
        STEP_REG  = 1'b0,
        STEP_ITEM = 1'b1
    } t_step_kind;

    // one row of the directed table: a register write or an item, with an
    // optional result that is known at a glance
    typedef struct packed {
        t_step_kind       kind;
        t_cfg_index       reg_index;
        logic [CFG_W-1:0] reg_value;
        t_in_item         item;
        logic             typed;
        t_out_item        result;
    } t_blur_step;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    t_in_item         i_in_item   = '0;
    logic             i_out_stall = 1'b0;
    logic             i_cfg_we    = 1'b0;
    t_cfg_index       i_cfg_index = CFG_FRAME_WIDTH;
    logic [CFG_W-1:0] i_cfg_data  = '0;
    logic             o_in_stall;
    logic             o_out_valid;
    t_out_item        o_out_item;

    box_blur_3x3_edge_normalized_top uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // blur predictor: own copy of the frame geometry, line history,
    // window and the input and output positions
    // ---------------------------------------------------------------
    logic [WIDTH_W-1:0]  blur_width;
    logic [HEIGHT_W-1:0] blur_height;
    t_pixel              older_rows [MAX_WIDTH];
    t_pixel              newer_rows [MAX_WIDTH];
    // index row*3 + col, row 0 is the top row of the window
    t_pixel              blur_window [9];
    logic [WIDTH_W-1:0]  in_col;
    logic [ROW_W-1:0]    in_row;
    logic [WIDTH_W-1:0]  out_col;
    logic [ROW_W-1:0]    out_row;

    // blurred pixels still owed by the block, oldest first
    t_out_item blurred_due [$];

    int  fault_count   = 0;
    int  live_items    = 0;
    int  cycle_count   = 0;
    bit  calm          = 1'b0;
    bit  hold_off_req  = 1'b0;
    bit  pressure_done = 1'b0;
    bit  wide_done     = 1'b0;

    t_blur_step step_table [$];

    function automatic void blur_restart();
        blur_window = '{default: '0};
        in_col  = '0;
        in_row  = '0;
        out_col = '0;
        out_row = '0;
    endfunction

    function automatic void blur_config(input t_cfg_index idx, input logic [CFG_W-1:0] value);
        logic [WIDTH_W-1:0] w;
        w = value[WIDTH_W-1:0];
        if (idx == CFG_FRAME_WIDTH) begin
            // zero counts as one, anything past the line store counts as its depth
            if (w == 0) blur_width = WIDTH_W'(1);
            else if (w > MAX_WIDTH) blur_width = WIDTH_W'(MAX_WIDTH);
            else blur_width = w;
        end else begin
            blur_height = (value == 0) ? HEIGHT_W'(1) : value;
        end
        blur_restart();
    endfunction

    // mean of the in-frame neighbours of the current output pixel; right_aligned
    // when the output column sits in the right column of the window
    function automatic t_out_item average_window(input bit right_aligned);
        int unsigned sum [3];
        int unsigned n;
        int          slot;
        bit          row_in;
        bit          col_in;
        t_out_item   mean;
        sum = '{default: 0};
        n = 0;
        for (int dy = -1; dy <= 1; dy++) begin
            row_in = !((dy < 0 && out_row == 0) || (dy > 0 && out_row + 1 >= blur_height));
            for (int dx = -1; dx <= 1; dx++) begin
                col_in = !((dx < 0 && out_col == 0) || (dx > 0 && out_col + 1 >= blur_width));
                slot = dx + 1 + int'(right_aligned);
                if (row_in && col_in && slot <= 2) begin
                    for (int ch = 0; ch < 3; ch++)
                        sum[ch] += 32'(blur_window[(dy + 1) * 3 + slot][ch]);
                    n++;
                end
            end
        end
        // round half up with exact integer division
        mean.red_out   = 8'((2 * sum[2] + n) / (2 * n));
        mean.green_out = 8'((2 * sum[1] + n) / (2 * n));
        mean.blue_out  = 8'((2 * sum[0] + n) / (2 * n));
        mean.frame_end = (out_row + 1 >= blur_height) && (out_col + 1 >= blur_width);
        out_col++;
        if (out_col >= blur_width) begin
            out_col = '0;
            out_row++;
        end
        return mean;
    endfunction

    function automatic void blur_step(input t_in_item it, output bit took, output bit made,
                                      output t_out_item res);
        logic [WIDTH_W-1:0] col;
        t_pixel             fresh;
        t_pixel             upper;
        t_pixel             middle;
        bit                 draining;
        bit                 done;
        took = 1'b0;
        made = 1'b0;
        res  = '0;
        done = 1'b0;
        draining = (in_row >= blur_height);
        // drain before the frame is in, or pixel while draining: ignored
        if ((it.mode == MODE_DRAIN) != draining) return;
        took = 1'b1;
        fresh = (it.mode == MODE_PIXEL) ? t_pixel'({it.red_in, it.green_in, it.blue_in}) : '0;
        col = in_col;
        // start of a row finishes the last pixel of the row two above
        if (col == 0 && in_row >= 2) begin
            res  = average_window(1'b1);
            made = 1'b1;
            done = res.frame_end;
        end
        upper  = older_rows[col];
        middle = newer_rows[col];
        older_rows[col] = middle;
        newer_rows[col] = fresh;
        for (int r = 0; r < 3; r++) begin
            blur_window[r * 3]     = blur_window[r * 3 + 1];
            blur_window[r * 3 + 1] = blur_window[r * 3 + 2];
        end
        blur_window[2] = upper;
        blur_window[5] = middle;
        blur_window[8] = fresh;
        if (col >= 1 && in_row >= 1) begin
            res  = average_window(1'b0);
            made = 1'b1;
            done = res.frame_end;
        end
        in_col = col + 1'b1;
        if (in_col >= blur_width) begin
            in_col = '0;
            in_row++;
        end
        if (done) blur_restart();
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------
    function automatic t_blur_step reg_row(input t_cfg_index idx, input logic [CFG_W-1:0] val);
        reg_row = '0;
        reg_row.kind      = STEP_REG;
        reg_row.reg_index = idx;
        reg_row.reg_value = val;
    endfunction

    function automatic t_blur_step pixel_row(input logic [7:0] r, input logic [7:0] g,
                                             input logic [7:0] b);
        pixel_row = '0;
        pixel_row.kind = STEP_ITEM;
        pixel_row.item = '{mode: MODE_PIXEL, red_in: r, green_in: g, blue_in: b};
    endfunction

    function automatic t_blur_step drain_row();
        drain_row = '0;
        drain_row.kind = STEP_ITEM;
        drain_row.item.mode = MODE_DRAIN;
    endfunction

    function automatic t_blur_step with_result(input t_blur_step s, input logic [7:0] r,
                                               input logic [7:0] g, input logic [7:0] b,
                                               input logic fe);
        with_result = s;
        with_result.typed  = 1'b1;
        with_result.result = '{red_out: r, green_out: g, blue_out: b, frame_end: fe};
    endfunction

    function automatic t_in_item pixel_item();
        pixel_item = '{mode: MODE_PIXEL, red_in: 8'($urandom), green_in: 8'($urandom),
                       blue_in: 8'($urandom)};
    endfunction

    // drain payload is unused, randomize it anyway
    function automatic t_in_item drain_item();
        drain_item = pixel_item();
        drain_item.mode = MODE_DRAIN;
    endfunction

    // sender gap: mostly none, some short, a few long
    function automatic int gap_len();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 15);
        if (r < 9) return 0;
        if (r < 15) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic note_fault(input string msg);
        fault_count++;
        if (fault_count <= 10) $display("%s", msg);
    endtask

    // offer one item until taken, then predict what it causes
    task automatic push_item(input t_in_item it, input bit typed, input t_out_item typed_res);
        bit        took;
        bit        made;
        t_out_item res;
        int        gap;
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        blur_step(it, took, made, res);
        if (typed) blurred_due.push_back(typed_res);
        else if (made) blurred_due.push_back(res);
        if (took) live_items++;
        gap = gap_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // register writes only with the block idle: all owed results back and the
    // pipeline given time to empty of items that cause no result
    task automatic write_reg(input t_cfg_index idx, input logic [CFG_W-1:0] val);
        i_in_valid <= 1'b0;
        while (blurred_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        blur_config(idx, val);
    endtask

    // pixels of one frame, optionally the closing drain ticks; noisy adds
    // early drains and pixels during the drain that the block must ignore
    task automatic feed_frame(input int pixel_count, input bit with_drains, input bit noisy);
        for (int n = 0; n < pixel_count; n++) begin
            if (noisy && $urandom_range(0, 15) == 0) push_item(drain_item(), 1'b0, '0);
            push_item(pixel_item(), 1'b0, '0);
        end
        if (with_drains) begin
            for (int n = 0; n <= int'(blur_width); n++) begin
                if (noisy && $urandom_range(0, 15) == 0) push_item(pixel_item(), 1'b0, '0);
                push_item(drain_item(), 1'b0, '0);
            end
            // drain right after frame end is too early for the next frame
            if (noisy && $urandom_range(0, 3) == 0) push_item(drain_item(), 1'b0, '0);
        end
    endtask

    // ---------------------------------------------------------------
    // result receiver: random stalls, calm stretches, one long hold-off
    // ---------------------------------------------------------------
    initial begin : result_receiver
        int span;
        bit hold;
        @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                // long hold-off while the sender keeps offering items
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off_req = 1'b0;
            end else if (calm) begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                hold = ($urandom_range(0, 3) == 0);
                if (!hold) span = $urandom_range(1, 12);
                else if ($urandom_range(0, 9) == 0) span = $urandom_range(15, 50);
                else span = $urandom_range(1, 3);
                i_out_stall <= hold;
                repeat (span) @(posedge i_clk);
            end
        end
    end

    // ---------------------------------------------------------------
    // result check: every taken result against the oldest owed pixel
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (blurred_due.size() == 0) begin
                note_fault($sformatf("cycle %0d: unexpected result r%02h g%02h b%02h end %0b",
                           cycle_count, o_out_item.red_out, o_out_item.green_out,
                           o_out_item.blue_out, o_out_item.frame_end));
            end else begin
                want = blurred_due.pop_front();
                if (o_out_item.red_out !== want.red_out
                        || o_out_item.green_out !== want.green_out
                        || o_out_item.blue_out !== want.blue_out
                        || o_out_item.frame_end !== want.frame_end) begin
                    note_fault($sformatf({"cycle %0d: expected r%02h g%02h b%02h end %0b,",
                               " got r%02h g%02h b%02h end %0b"}, cycle_count,
                               want.red_out, want.green_out, want.blue_out, want.frame_end,
                               o_out_item.red_out, o_out_item.green_out,
                               o_out_item.blue_out, o_out_item.frame_end));
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus: directed table, then random frames
    // ---------------------------------------------------------------
    initial begin : stimulus
        int               pick;
        int               pixels;
        int               wval;
        bit               write_w;
        bit               write_h;
        logic [CFG_W-1:0] wdata;
        logic [CFG_W-1:0] hdata;

        // predictor after reset: 640x480, empty history
        blur_width  = WIDTH_RESET;
        blur_height = HEIGHT_RESET;
        older_rows  = '{default: '0};
        newer_rows  = '{default: '0};
        blur_restart();

        step_table = '{
            // widths and heights of zero count as one: 1x1 frames
            reg_row(CFG_FRAME_WIDTH, 16'd0),
            reg_row(CFG_FRAME_HEIGHT, 16'd0),
            // drain before the last pixel is in: ignored
            drain_row(),
            pixel_row(8'hFF, 8'h00, 8'h80),
            // pixel while draining: ignored
            pixel_row(8'h11, 8'h22, 8'h33),
            drain_row(),
            // a lone pixel is its own mean
            with_result(drain_row(), 8'hFF, 8'h00, 8'h80, 1'b1),
            // next frame follows straight after frame end
            pixel_row(8'h00, 8'hFF, 8'h7F),
            drain_row(),
            with_result(drain_row(), 8'h00, 8'hFF, 8'h7F, 1'b1),
            // 3x2 frame at full scale stays at full scale
            reg_row(CFG_FRAME_WIDTH, 16'd3),
            reg_row(CFG_FRAME_HEIGHT, 16'd2),
            pixel_row(8'hFF, 8'hFF, 8'hFF),
            pixel_row(8'hFF, 8'hFF, 8'hFF),
            pixel_row(8'hFF, 8'hFF, 8'hFF),
            pixel_row(8'hFF, 8'hFF, 8'hFF),
            with_result(pixel_row(8'hFF, 8'hFF, 8'hFF), 8'hFF, 8'hFF, 8'hFF, 1'b0),
            with_result(pixel_row(8'hFF, 8'hFF, 8'hFF), 8'hFF, 8'hFF, 8'hFF, 1'b0),
            with_result(drain_row(), 8'hFF, 8'hFF, 8'hFF, 1'b0),
            with_result(drain_row(), 8'hFF, 8'hFF, 8'hFF, 1'b0),
            with_result(drain_row(), 8'hFF, 8'hFF, 8'hFF, 1'b0),
            with_result(drain_row(), 8'hFF, 8'hFF, 8'hFF, 1'b1),
            // tallest frame, left unfinished: the next write restarts it
            reg_row(CFG_FRAME_WIDTH, 16'd2),
            reg_row(CFG_FRAME_HEIGHT, 16'hFFFF),
            pixel_row(8'h00, 8'h00, 8'h00),
            pixel_row(8'hFF, 8'hFF, 8'hFF),
            pixel_row(8'h01, 8'h80, 8'h7F),
            pixel_row(8'h80, 8'h01, 8'hFE)
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (step_table[k]) begin
            if (step_table[k].kind == STEP_REG)
                write_reg(step_table[k].reg_index, step_table[k].reg_value);
            else
                push_item(step_table[k].item, step_table[k].typed, step_table[k].result);
        end

        while (live_items < ITEM_GOAL) begin
            calm = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 15);
            if (!pressure_done) begin
                // receiver holds off while a whole frame is offered
                calm = 1'b0;
                write_reg(CFG_FRAME_WIDTH, 16'd8);
                write_reg(CFG_FRAME_HEIGHT, 16'd4);
                hold_off_req  = 1'b1;
                pressure_done = 1'b1;
                feed_frame(32, 1'b1, 1'b0);
            end else if (!wide_done && live_items > ITEM_GOAL / 2) begin
                // all width bits set: clamps to the line store depth, run into row two
                wide_done = 1'b1;
                write_reg(CFG_FRAME_WIDTH, 16'h07FF);
                write_reg(CFG_FRAME_HEIGHT, 16'hFFFF);
                feed_frame(MAX_WIDTH + $urandom_range(8, 40), 1'b0, 1'b0);
            end else if (pick == 0) begin
                // tall frame cut off after a few rows
                write_reg(CFG_FRAME_WIDTH, 16'($urandom_range(1, 8)));
                hdata = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(100, 65534));
                write_reg(CFG_FRAME_HEIGHT, hdata);
                feed_frame(int'(blur_width) * $urandom_range(2, 5), 1'b0, 1'b1);
            end else begin
                case ($urandom_range(0, 9))
                    0:       wval = 0;
                    1, 2:    wval = $urandom_range(9, 48);
                    default: wval = $urandom_range(1, 8);
                endcase
                wdata = 16'(wval);
                // junk above the width field
                if ($urandom_range(0, 3) == 0)
                    wdata[CFG_W-1:WIDTH_W] = (CFG_W - WIDTH_W)'($urandom);
                hdata = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 6));
                write_w = ($urandom_range(0, 1) == 1);
                write_h = !write_w || ($urandom_range(0, 1) == 1);
                // never keep a leftover large frame
                if (blur_width > 48 || blur_height > 6) begin
                    write_w = 1'b1;
                    write_h = 1'b1;
                end
                if (write_w) write_reg(CFG_FRAME_WIDTH, wdata);
                if (write_h) write_reg(CFG_FRAME_HEIGHT, hdata);
                pixels = int'(blur_width) * int'(blur_height);
                if (pick == 1) begin
                    // broken frame, restarted by the next write
                    feed_frame($urandom_range(0, pixels - 1), 1'b0, 1'b1);
                end else begin
                    repeat ($urandom_range(1, 3)) feed_frame(pixels, 1'b1, pick < 6);
                end
            end
        end

        i_in_valid <= 1'b0;
        while (blurred_due.size() != 0) @(posedge i_clk);
        repeat (4 * SETTLE_CYCLES) @(posedge i_clk);
        if (fault_count == 0 && blurred_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
